// File: hdl/dfst_pkg.sv
package dfst_pkg;

    // defaults for the top level parameters
    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_DEGREE_DEF   = 16;

    // fixed field widths
    localparam int VERT_W   = 4;
    localparam int VCOUNT_W = 5;
    localparam int STATUS_W = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 5'd16;

    // request kinds
    localparam logic OP_ADD = 1'b0;
    localparam logic OP_RUN = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TREE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

endpackage

// File: hdl/dfs_spanning_tree_core.sv
// Depth-first spanning tree engine over an undirected graph held in memory.
// Requests enter on the s_axis channel: tuser selects add-edge or run, tdata
// carries both edge ends. Results leave on the m_axis channel: tuser holds
// the status, tdata the tree edge, tlast marks the final result of a request.
// The cfg channel writes the vertex count; write it only while the block idles.
// An add-edge request gives one result; a rejected one ends after the degree
// read and its evaluation, a stored one goes on through the degree read, first
// list write and second list write (one write port on the neighbor memory).
// A run clears the visited marks and walks from vertex 0. Each list entry it
// examines takes registered degree and neighbor reads, then the evaluation;
// each tree edge adds the steps that find the child's list done and return to
// the parent (read, evaluation, stack read), plus start and finish steps.
// Tree edges are held one back so that the last can carry tlast.
// Reset empties all lists (degree valid bits clear at once, no clearing pass),
// sets the vertex count to 16 (the default vertex maximum) and leaves the block idle.
// A stalled receiver holds the output register; the walk waits only when it has
// a new tree edge and both the held edge and the output register are full, and
// add-edge and final results wait for the output register to free up.
// s_axis_tready is high whenever no request is in progress.
module dfs_spanning_tree_core #(
    parameter int MAX_VERTICES = dfst_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = dfst_pkg::MAX_DEGREE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request channel
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dfst_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // first_vertex, second_vertex
    input  logic                              s_axis_tuser,  // op
    // result channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dfst_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // edge_from, edge_to
    output logic [dfst_pkg::STATUS_W-1:0]     m_axis_tuser,  // status
    output logic                              m_axis_tlast,  // last
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dfst_pkg::VCOUNT_W-1:0]     cfg_data       // vertex_count
);
    import dfst_pkg::*;

    localparam int VIDX_W  = $clog2(MAX_VERTICES);
    localparam int DEG_W   = $clog2(MAX_DEGREE + 1);
    localparam int DEPTH_W = $clog2(MAX_VERTICES + 1);
    localparam int NB_DEPTH = MAX_VERTICES * MAX_DEGREE;
    localparam int ADDR_W  = $clog2(NB_DEPTH);
    localparam int STK_W   = VIDX_W + DEG_W;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_ADD_EVAL  = 3'd1;
    localparam logic [2:0] S_ADD_WR2   = 3'd2;
    localparam logic [2:0] S_WALK_RD   = 3'd3;
    localparam logic [2:0] S_WALK_EVAL = 3'd4;
    localparam logic [2:0] S_WALK_POP  = 3'd5;
    localparam logic [2:0] S_WALK_FIN  = 3'd6;

    // control registers
    logic [2:0]              state_reg, state_next;
    logic [VCOUNT_W-1:0]     vcount_reg;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] deg_vld_reg;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic                    pend_valid_reg, pend_valid_next;
    logic                    m_valid_reg;

    // payload registers
    logic [VERT_W-1:0]       u_reg, u_next;
    logic [VERT_W-1:0]       v_reg, v_next;
    logic [VIDX_W-1:0]       top_v_reg, top_v_next;
    logic [DEG_W-1:0]        top_i_reg, top_i_next;
    logic [VIDX_W-1:0]       pend_from_reg, pend_from_next;
    logic [VIDX_W-1:0]       pend_to_reg, pend_to_next;
    logic [STATUS_W-1:0]     m_status_reg;
    logic [VERT_W-1:0]       m_from_reg;
    logic [VERT_W-1:0]       m_to_reg;
    logic                    m_last_reg;

    // memories and their registered read data
    logic [DEG_W-1:0]  deg_mem [MAX_VERTICES];
    logic [VERT_W-1:0] nb_mem  [NB_DEPTH];
    logic [STK_W-1:0]  stk_mem [MAX_VERTICES];
    logic [DEG_W-1:0]  deg_a_reg, deg_b_reg;
    logic              deg_a_vld_reg, deg_b_vld_reg;
    logic [VERT_W-1:0] nb_rd_reg;
    logic [STK_W-1:0]  stk_rd_reg;

    // memory port controls
    logic              deg_re;
    logic [VIDX_W-1:0] deg_raddr_a, deg_raddr_b;
    logic              deg_we;
    logic [VIDX_W-1:0] deg_waddr;
    logic [DEG_W-1:0]  deg_wdata;
    logic              nb_re, nb_we;
    logic [ADDR_W-1:0] nb_raddr, nb_waddr;
    logic [VERT_W-1:0] nb_wdata;
    logic              stk_re, stk_we;
    logic [VIDX_W-1:0] stk_raddr, stk_waddr;
    logic [STK_W-1:0]  stk_wdata;

    // output load
    logic                out_free;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
    logic [VERT_W-1:0]   out_from, out_to;
    logic                out_last;

    // decoded helpers
    logic [DEG_W-1:0]   du, dv, dv2;
    logic [VIDX_W-1:0]  u_idx, v_idx, w_idx;
    logic               reject;
    logic               hit;
    logic [DEPTH_W-1:0] depth_m1;
    logic [VERT_W-1:0]  in_first, in_second;

    assign in_first  = s_axis_tdata[VERT_W-1:0];
    assign in_second = s_axis_tdata[2*VERT_W-1:VERT_W];

    // degree reads from entries never written count as zero
    assign du = deg_a_vld_reg ? deg_a_reg : '0;
    assign dv = deg_b_vld_reg ? deg_b_reg : '0;
    assign dv2 = (u_reg == v_reg) ? du + DEG_W'(1) : dv;
    assign u_idx = VIDX_W'(u_reg);
    assign v_idx = VIDX_W'(v_reg);
    assign w_idx = VIDX_W'(nb_rd_reg);
    assign depth_m1 = depth_reg - DEPTH_W'(1);

    // range and capacity check for an edge
    always_comb
    begin
        reject = 1'b0;
        if (int'(u_reg) >= MAX_VERTICES || int'(v_reg) >= MAX_VERTICES ||
            {1'b0, u_reg} >= vcount_reg || {1'b0, v_reg} >= vcount_reg)
        begin
            reject = 1'b1;
        end
        else if (u_reg == v_reg)
        begin
            reject = (int'(du) + 2) > MAX_DEGREE;
        end
        else
        begin
            reject = (int'(du) >= MAX_DEGREE) || (int'(dv) >= MAX_DEGREE);
        end
    end

    // neighbor found by the walk becomes a tree edge
    assign hit = (int'(nb_rd_reg) < MAX_VERTICES) && !visited_reg[w_idx] &&
                 (int'(depth_reg) < MAX_VERTICES);

    assign out_free = !m_valid_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        visited_next    = visited_reg;
        depth_next      = depth_reg;
        pend_valid_next = pend_valid_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        top_v_next      = top_v_reg;
        top_i_next      = top_i_reg;
        pend_from_next  = pend_from_reg;
        pend_to_next    = pend_to_reg;
        deg_re      = 1'b0;
        deg_raddr_a = top_v_reg;
        deg_raddr_b = top_v_reg;
        deg_we      = 1'b0;
        deg_waddr   = u_idx;
        deg_wdata   = du + DEG_W'(1);
        nb_re       = 1'b0;
        nb_raddr    = ADDR_W'(int'(top_v_reg) * MAX_DEGREE + int'(top_i_reg));
        nb_we       = 1'b0;
        nb_waddr    = ADDR_W'(int'(u_idx) * MAX_DEGREE + int'(du));
        nb_wdata    = v_reg;
        stk_re      = 1'b0;
        stk_raddr   = VIDX_W'(depth_m1 - DEPTH_W'(1));
        stk_we      = 1'b0;
        stk_waddr   = VIDX_W'(depth_m1);
        stk_wdata   = {top_v_reg, top_i_reg + DEG_W'(1)};
        out_load    = 1'b0;
        out_status  = ST_ACCEPT;
        out_from    = '0;
        out_to      = '0;
        out_last    = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == OP_RUN)
                    begin
                        visited_next    = '0;
                        visited_next[0] = 1'b1;
                        top_v_next      = '0;
                        top_i_next      = '0;
                        depth_next      = DEPTH_W'(1);
                        pend_valid_next = 1'b0;
                        state_next      = S_WALK_RD;
                    end
                    else
                    begin
                        u_next      = in_first;
                        v_next      = in_second;
                        deg_re      = 1'b1;
                        deg_raddr_a = VIDX_W'(in_first);
                        deg_raddr_b = VIDX_W'(in_second);
                        state_next  = S_ADD_EVAL;
                    end
                end
            end
            S_ADD_EVAL:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (reject)
                    begin
                        out_status = ST_REJECT;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        out_status = ST_ACCEPT;
                        nb_we      = 1'b1;
                        deg_we     = 1'b1;
                        state_next = S_ADD_WR2;
                    end
                end
            end
            S_ADD_WR2:
            begin
                // second end; a self-loop takes the next slot of the same list
                nb_we      = 1'b1;
                nb_waddr   = ADDR_W'(int'(v_idx) * MAX_DEGREE + int'(dv2));
                nb_wdata   = u_reg;
                deg_we     = 1'b1;
                deg_waddr  = v_idx;
                deg_wdata  = dv2 + DEG_W'(1);
                state_next = S_IDLE;
            end
            S_WALK_RD:
            begin
                deg_re     = 1'b1;
                nb_re      = 1'b1;
                state_next = S_WALK_EVAL;
            end
            S_WALK_EVAL:
            begin
                if (top_i_reg < du)
                begin
                    if (!(hit && pend_valid_reg && !out_free))
                    begin
                        top_i_next = top_i_reg + DEG_W'(1);
                        state_next = S_WALK_RD;
                        if (hit)
                        begin
                            // flush the held edge, hold the new one, push
                            if (pend_valid_reg)
                            begin
                                out_load   = 1'b1;
                                out_status = ST_TREE;
                                out_from   = VERT_W'(pend_from_reg);
                                out_to     = VERT_W'(pend_to_reg);
                                out_last   = 1'b0;
                            end
                            pend_valid_next     = 1'b1;
                            pend_from_next      = top_v_reg;
                            pend_to_next        = w_idx;
                            visited_next[w_idx] = 1'b1;
                            stk_we              = 1'b1;
                            top_v_next          = w_idx;
                            top_i_next          = '0;
                            depth_next          = depth_reg + DEPTH_W'(1);
                        end
                    end
                end
                else
                begin
                    // list done: return to the parent
                    depth_next = depth_m1;
                    if (depth_reg == DEPTH_W'(1))
                    begin
                        state_next = S_WALK_FIN;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        state_next = S_WALK_POP;
                    end
                end
            end
            S_WALK_POP:
            begin
                top_v_next = stk_rd_reg[STK_W-1:DEG_W];
                top_i_next = stk_rd_reg[DEG_W-1:0];
                state_next = S_WALK_RD;
            end
            S_WALK_FIN:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_status = ST_TREE;
                        out_from   = VERT_W'(pend_from_reg);
                        out_to     = VERT_W'(pend_to_reg);
                    end
                    else
                    begin
                        out_status = ST_EMPTY;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            vcount_reg     <= VCOUNT_RESET;
            visited_reg    <= '0;
            deg_vld_reg    <= '0;
            depth_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            visited_reg    <= visited_next;
            depth_reg      <= depth_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
            if (deg_we)
            begin
                deg_vld_reg[deg_waddr] <= 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        u_reg         <= u_next;
        v_reg         <= v_next;
        top_v_reg     <= top_v_next;
        top_i_reg     <= top_i_next;
        pend_from_reg <= pend_from_next;
        pend_to_reg   <= pend_to_next;
        if (out_load)
        begin
            m_status_reg <= out_status;
            m_from_reg   <= out_from;
            m_to_reg     <= out_to;
            m_last_reg   <= out_last;
        end
    end

    // degree memory, two read ports and one write port
    always_ff @(posedge clk)
    begin
        if (deg_we)
        begin
            deg_mem[deg_waddr] <= deg_wdata;
        end
        if (deg_re)
        begin
            deg_a_reg     <= deg_mem[deg_raddr_a];
            deg_b_reg     <= deg_mem[deg_raddr_b];
            deg_a_vld_reg <= deg_vld_reg[deg_raddr_a];
            deg_b_vld_reg <= deg_vld_reg[deg_raddr_b];
        end
    end

    // neighbor list memory
    always_ff @(posedge clk)
    begin
        if (nb_we)
        begin
            nb_mem[nb_waddr] <= nb_wdata;
        end
        if (nb_re)
        begin
            nb_rd_reg <= nb_mem[nb_raddr];
        end
    end

    // walk stack memory, entries below the cached top
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {m_to_reg, m_from_reg};
    assign m_axis_tlast  = m_last_reg;

    // stack never grows past MAX_VERTICES entries
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(depth_reg) <= MAX_VERTICES)
        else $error("walk stack depth out of range");

    // a run request starts the walk with only vertex 0 on the stack
    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_RUN) |=>
        (state_reg == S_WALK_RD && depth_reg == DEPTH_W'(1) && visited_reg[0]))
        else $error("walk did not start from vertex 0");

    // a stored degree never exceeds the list size
    a_deg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        deg_we |-> int'(deg_wdata) <= MAX_DEGREE)
        else $error("neighbor list overflow");

    // the walk only reads lists while the stack holds a vertex
    a_walk_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_RD || state_reg == S_WALK_EVAL) |-> depth_reg != '0)
        else $error("walk step with empty stack");

    // a loaded result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |-> !out_load)
        else $error("result overwritten while stalled");

endmodule
